// ===== hw/rtl/btb_bimodal_branch_predictor_assert.svh =====
// Assertion macros for the branch predictor RTL.
`ifndef BTB_BIMODAL_BRANCH_PREDICTOR_ASSERT_SVH
`define BTB_BIMODAL_BRANCH_PREDICTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btb assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btb assertion failed");

`endif

// ===== hw/rtl/btb_pkg.sv =====
// Shared types and constants for the bimodal branch predictor.
`default_nettype none

package btb_pkg;

   localparam int TARGET_ENTRIES_DEF  = 64;
   localparam int COUNTER_ENTRIES_DEF = 256;

   localparam int PC_WIDTH  = 32;
   localparam int TAG_LSB   = 8;
   localparam int TAG_WIDTH = PC_WIDTH - TAG_LSB;
   localparam int IDX_LSB   = 2;

   localparam logic [1:0] OP_PREDICT = 2'd0;
   localparam logic [1:0] OP_BRANCH  = 2'd1;
   localparam logic [1:0] OP_JUMP    = 2'd2;

   localparam logic [1:0] CTR_RESET = 2'd1;
   localparam logic [1:0] CTR_MAX   = 2'd3;
   localparam logic [1:0] CTR_MIN   = 2'd0;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [PC_WIDTH-1:0] pc;
      logic                taken;
      logic [PC_WIDTH-1:0] target;
   } req_type;

   typedef struct packed {
      logic                predicted;
      logic [PC_WIDTH-1:0] next_pc;
      logic                redirect;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic                 is_jump;
      logic [TAG_WIDTH-1:0] tag;
      logic [PC_WIDTH-1:0]  target;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/btb_bimodal_branch_predictor.sv =====
// Bimodal branch predictor with a direct-mapped branch target buffer.
//
//   channel   ports                        handshake
//   -------   --------------------------   ----------------------------------
//   request   start, busy, req_word        taken when start & !busy
//   result    rsp_strobe, rsp_word         valid for one cycle, cannot stall
//
// One word per cycle while busy is low; each result passes the s1 and output registers.
// The rate is set by the single write port of each table, used at most once per word.
// After reset, busy stays high while both tables are swept clear, one entry
// per cycle, over max(TARGET_ENTRIES, COUNTER_ENTRIES) entries.
// Back-to-back words to the same entry are forwarded from the last write.
// Table depths are powers of two.
`default_nettype none

module btb_bimodal_branch_predictor #(
   parameter int TARGET_ENTRIES  = btb_pkg::TARGET_ENTRIES_DEF,
   parameter int COUNTER_ENTRIES = btb_pkg::COUNTER_ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire btb_pkg::req_type req_word,
   output      logic             rsp_strobe,
   output      btb_pkg::rsp_type rsp_word
);

`include "btb_bimodal_branch_predictor_assert.svh"

   localparam int TIDX    = $clog2(TARGET_ENTRIES);
   localparam int CIDX    = $clog2(COUNTER_ENTRIES);
   localparam int CLR_LEN = (TARGET_ENTRIES > COUNTER_ENTRIES) ? TARGET_ENTRIES
                                                               : COUNTER_ENTRIES;
   localparam int CW      = $clog2(CLR_LEN);

   btb_pkg::entry_type buf_mem [TARGET_ENTRIES];
   logic [1:0]         ctr_mem [COUNTER_ENTRIES];

   logic               clearing_ff;
   logic [CW-1:0]      clr_idx_ff;

   logic               s1_valid_ff;
   btb_pkg::req_type   s1_req_ff;
   btb_pkg::entry_type buf_q_ff;
   logic [1:0]         ctr_q_ff;

   logic               bwr_valid_ff;
   logic [TIDX-1:0]    bwr_idx_ff;
   btb_pkg::entry_type bwr_data_ff;
   logic               cwr_valid_ff;
   logic [CIDX-1:0]    cwr_idx_ff;
   logic [1:0]         cwr_data_ff;

   logic               rsp_strobe_ff;
   btb_pkg::rsp_type   rsp_word_ff;

   logic               accept;
   logic [TIDX-1:0]    req_bidx;
   logic [CIDX-1:0]    req_cidx;
   logic [TIDX-1:0]    s1_bidx;
   logic [CIDX-1:0]    s1_cidx;
   btb_pkg::entry_type entry;
   logic [1:0]         ctr;
   logic [btb_pkg::PC_WIDTH-1:0] seq_pc;
   logic               hit;
   logic [1:0]         ctr_next;
   btb_pkg::rsp_type   rsp_in;

   logic               buf_we;
   logic [TIDX-1:0]    buf_widx;
   btb_pkg::entry_type buf_wdata;
   logic               ctr_we;
   logic [CIDX-1:0]    ctr_widx;
   logic [1:0]         ctr_wdata;

   assign busy   = clearing_ff;
   assign accept = start & ~clearing_ff;

   assign req_bidx = req_word.pc[btb_pkg::IDX_LSB +: TIDX];
   assign req_cidx = req_word.pc[btb_pkg::IDX_LSB +: CIDX];
   assign s1_bidx  = s1_req_ff.pc[btb_pkg::IDX_LSB +: TIDX];
   assign s1_cidx  = s1_req_ff.pc[btb_pkg::IDX_LSB +: CIDX];

   // forward the write made at the same edge as this word's table read
   assign entry = (bwr_valid_ff && bwr_idx_ff == s1_bidx) ? bwr_data_ff : buf_q_ff;
   assign ctr   = (cwr_valid_ff && cwr_idx_ff == s1_cidx) ? cwr_data_ff : ctr_q_ff;

   assign seq_pc = s1_req_ff.pc + 32'd4;
   assign hit    = entry.valid && entry.tag == s1_req_ff.pc[btb_pkg::PC_WIDTH-1:btb_pkg::TAG_LSB];

   always_comb begin
      if (s1_req_ff.taken) begin
         ctr_next = (ctr == btb_pkg::CTR_MAX) ? ctr : ctr + 2'd1;
      end else begin
         ctr_next = (ctr == btb_pkg::CTR_MIN) ? ctr : ctr - 2'd1;
      end
   end

   always_comb begin
      rsp_in.predicted = 1'b0;
      rsp_in.next_pc   = seq_pc;
      rsp_in.redirect  = 1'b0;
      unique case (s1_req_ff.opcode)
         btb_pkg::OP_PREDICT: begin
            rsp_in.predicted = hit & (entry.is_jump | ctr[1]);
            rsp_in.next_pc   = (hit & (entry.is_jump | ctr[1])) ? entry.target : seq_pc;
         end
         btb_pkg::OP_BRANCH: begin
            rsp_in.predicted = ctr[1];
            rsp_in.next_pc   = s1_req_ff.taken ? s1_req_ff.target : seq_pc;
            rsp_in.redirect  = s1_req_ff.taken ^ ctr[1];
         end
         btb_pkg::OP_JUMP: begin
            rsp_in.next_pc  = s1_req_ff.target;
            rsp_in.redirect = 1'b1;
         end
         default: begin
            rsp_in.predicted = 1'b0;
         end
      endcase
   end

   always_comb begin
      buf_we = clearing_ff | (s1_valid_ff & (s1_req_ff.opcode == btb_pkg::OP_BRANCH ||
                                             s1_req_ff.opcode == btb_pkg::OP_JUMP));
      ctr_we = clearing_ff | (s1_valid_ff & (s1_req_ff.opcode == btb_pkg::OP_BRANCH));
      if (clearing_ff) begin
         buf_widx  = clr_idx_ff[TIDX-1:0];
         buf_wdata = '0;
         ctr_widx  = clr_idx_ff[CIDX-1:0];
         ctr_wdata = btb_pkg::CTR_RESET;
      end else begin
         buf_widx          = s1_bidx;
         buf_wdata.valid   = 1'b1;
         buf_wdata.is_jump = (s1_req_ff.opcode == btb_pkg::OP_JUMP);
         buf_wdata.tag     = s1_req_ff.pc[btb_pkg::PC_WIDTH-1:btb_pkg::TAG_LSB];
         buf_wdata.target  = s1_req_ff.target;
         ctr_widx          = s1_cidx;
         ctr_wdata         = ctr_next;
      end
   end

   // tables: read-first, registered read
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_widx] <= buf_wdata;
      end
      if (ctr_we) begin
         ctr_mem[ctr_widx] <= ctr_wdata;
      end
      buf_q_ff <= buf_mem[req_bidx];
      ctr_q_ff <= ctr_mem[req_cidx];
   end

   always_ff @(posedge clock) begin
      s1_req_ff   <= req_word;
      bwr_idx_ff  <= buf_widx;
      bwr_data_ff <= buf_wdata;
      cwr_idx_ff  <= ctr_widx;
      cwr_data_ff <= ctr_wdata;
      rsp_word_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         bwr_valid_ff  <= 1'b0;
         cwr_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + CW'(1);
            if (clr_idx_ff == CW'(CLR_LEN - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff   <= accept;
         bwr_valid_ff  <= buf_we;
         cwr_valid_ff  <= ctr_we;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   `BTB_ASSERT_NEXT(a_result_follows, clock, reset, s1_valid_ff, rsp_strobe)
   `BTB_ASSERT_NEXT(a_no_stray_result, clock, reset, !s1_valid_ff, !rsp_strobe)
   `BTB_ASSERT_NEXT(a_no_accept_busy, clock, reset, start && busy, !s1_valid_ff)
   `BTB_ASSERT_NEXT(a_jump_redirects, clock, reset,
      s1_valid_ff && s1_req_ff.opcode == btb_pkg::OP_JUMP,
      rsp_word.redirect && rsp_word.next_pc == $past(s1_req_ff.target))
   `BTB_ASSERT_NEXT(a_predict_no_redirect, clock, reset,
      s1_valid_ff && s1_req_ff.opcode == btb_pkg::OP_PREDICT, !rsp_word.redirect)

endmodule

`default_nettype wire
